// ===== rtl/core/fcirc_pkg.sv =====
// Shared types and constants for the circular-delay-line FIR filter.
// Item layouts, cell and MAC control groups, function codes, FSM states.
// No dependencies.
package fcirc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int ACC_BITS    = 64;
    localparam int FUNC_W      = 2;
    localparam int COEF_IDX_W  = 6;
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] CFG_TAPS_RESET = CFG_W'(64);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_FILTER = 2'd0,
        FN_COEF   = 2'd1,
        FN_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        sample_t               sample_in;
        logic [COEF_IDX_W-1:0] coef_index;
        sample_t               coef_value;
        logic                  block_end_in;
    } in_item_t;

    typedef struct packed {
        sample_t filtered_out;
        logic    clipped;
        logic    block_end_out;
    } out_item_t;

    // Broadcast to every tap cell
    typedef struct packed {
        logic                  hist_clr;
        logic                  hist_we;
        logic                  hist_rot;
        logic                  coef_we;
        logic                  coef_rot;
        sample_t               sample;
        logic [COEF_IDX_W-1:0] coef_index;
        sample_t               coef_value;
    } cell_ctl_t;

    typedef struct packed {
        logic clr;
        logic en;
    } mac_ctl_t;

endpackage

// ===== rtl/core/fir_filter_circular.sv =====
// FIR filter over a circular delay line: a row of tap cells and one shared MAC.
// A sample item writes history and clears the MAC when accepted, then sweeps
// the ring past the single MAC and loads the result in the emit state once the
// output register is free. Coefficient writes and clears finish on accept.
// Other items: one per cycle while idle; none is taken during sweep or emit.
// Reset: aresetn sync, active low; clears FSM, wp, cnt, valid; taps_in_use 64.
module fir_filter_circular import fcirc_pkg::*; #(
    parameter int MAX_TAPS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,

    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item,

    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int N_W   = $clog2(MAX_TAPS + 1);
    localparam int CNT_W = $clog2(2 * MAX_TAPS);
    localparam int SW    = N_W + 1;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    taps_reg;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                blk_reg, blk_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           out_reg, out_next;

    logic [N_W-1:0]      n_eff;
    logic [IDX_W-1:0]    p_start;
    logic [N_W-1:0]      p_inc;
    logic [SW-1:0]       cnt_w, p_w, n_w, two_n_m1;
    logic                in_win;
    logic                sweep_last;
    logic                out_free;
    logic                start;
    logic                clear_wp;
    logic                load_out;

    cell_ctl_t           cell_ctl;
    mac_ctl_t            mac_ctl;

    sample_t             hist_q    [MAX_TAPS];
    sample_t             coef_q    [MAX_TAPS];
    sample_t             coef_tail [MAX_TAPS];
    sample_t             coef_wrap;
    sample_t             mac_y;
    logic                mac_clip;

    // Effective tap count: zero acts as one, above the build size clamps.
    always_comb begin
        if (taps_reg == '0) begin
            n_eff = N_W'(1);
        end else if (int'(taps_reg) > MAX_TAPS) begin
            n_eff = N_W'(MAX_TAPS);
        end else begin
            n_eff = N_W'(taps_reg);
        end
    end

    // Pointer left beyond a shrunken ring restarts at slot zero.
    assign p_start = (N_W'(wp_reg) >= n_eff) ? '0 : wp_reg;
    assign p_inc   = N_W'(p_start) + N_W'(1);

    // Sweep timing. History turns 2*N times (back home); coefficients turn
    // N times inside the window starting at count p, which lines up
    // coefficient k with the sample k steps back at the head cell.
    assign cnt_w      = SW'(cnt_reg);
    assign p_w        = SW'(p_reg);
    assign n_w        = SW'(n_eff);
    assign two_n_m1   = {n_eff, 1'b0} - SW'(1);
    assign in_win     = (cnt_w >= p_w) && (cnt_w < (p_w + n_w));
    assign sweep_last = (cnt_w == two_n_m1);
    assign out_free   = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_item.func == FN_FILTER)) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready             = 1'b0;
        start               = 1'b0;
        clear_wp            = 1'b0;
        load_out            = 1'b0;
        mac_ctl             = '0;
        cell_ctl            = '0;
        cell_ctl.sample     = s_item.sample_in;
        cell_ctl.coef_index = s_item.coef_index;
        cell_ctl.coef_value = s_item.coef_value;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_item.func)
                        FN_FILTER: begin
                            cell_ctl.hist_we = 1'b1;
                            mac_ctl.clr      = 1'b1;
                            start            = 1'b1;
                        end
                        FN_COEF: begin
                            cell_ctl.coef_we = 1'b1;
                        end
                        FN_CLEAR: begin
                            cell_ctl.hist_clr = 1'b1;
                            clear_wp          = 1'b1;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                cell_ctl.hist_rot = 1'b1;
                cell_ctl.coef_rot = in_win;
                mac_ctl.en        = in_win;
            end
            ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        wp_next      = wp_reg;
        p_next       = p_reg;
        cnt_next     = cnt_reg;
        blk_next     = blk_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (clear_wp) begin
            wp_next = '0;
        end else if (start) begin
            wp_next = (p_inc == n_eff) ? '0 : IDX_W'(p_inc);
        end

        if (start) begin
            p_next   = p_start;
            cnt_next = '0;
            blk_next = s_item.block_end_in;
        end else if (state_reg == ST_SWEEP) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (load_out) begin
            out_next.filtered_out  = mac_y;
            out_next.clipped       = mac_clip;
            out_next.block_end_out = blk_reg;
            m_valid_next           = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            taps_reg    <= CFG_TAPS_RESET;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                taps_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg   <= p_next;
        blk_reg <= blk_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // ------------------------------------------------------------------
    // Tap cell row. History moves toward cell 0 and closes from cell 0
    // into the last ring cell; coefficients move away from cell 0 and
    // close from the last ring cell back into cell 0.
    // ------------------------------------------------------------------
    always_comb begin
        coef_wrap = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            coef_wrap = coef_wrap | coef_tail[i];
        end
    end

    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
        sample_t hist_up;
        sample_t coef_dn;

        if (i < MAX_TAPS - 1) begin : g_up
            assign hist_up = hist_q[i+1];
        end else begin : g_top
            assign hist_up = hist_q[0];
        end

        if (i > 0) begin : g_dn
            assign coef_dn = coef_q[i-1];
        end else begin : g_bot
            assign coef_dn = coef_wrap;
        end

        fcirc_cell #(
            .MAX_TAPS (MAX_TAPS),
            .IDX      (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl),
            .wr_pos    (p_start),
            .tap_cnt   (n_eff),
            .hist_head (hist_q[0]),
            .hist_up   (hist_up),
            .coef_dn   (coef_dn),
            .hist_q    (hist_q[i]),
            .coef_q    (coef_q[i]),
            .coef_tail (coef_tail[i])
        );
    end

    // Shared MAC at the head of the row
    fcirc_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .hist_tap (hist_q[0]),
        .coef_tap (coef_q[0]),
        .y        (mac_y),
        .clip     (mac_clip)
    );

`ifndef SYNTHESIS
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit state");

    a_filter_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.func == FN_FILTER)) |=> (state_reg == ST_SWEEP))
        else $error("filter item did not start a sweep");

    a_sweep_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (cnt_w <= two_n_m1))
        else $error("sweep counter ran past its end");

    a_sweep_ptr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (p_w < n_w))
        else $error("write slot outside ring during sweep");
`endif

endmodule

// ===== rtl/core/fcirc_cell.sv =====
// One tap cell: holds one history sample and one coefficient at its ring slot.
// Rotates history toward cell 0 and coefficients away from it during a sweep.
// Depends on fcirc_pkg.
module fcirc_cell import fcirc_pkg::*; #(
    parameter int MAX_TAPS = 64,
    parameter int IDX      = 0,
    localparam int IDX_W   = $clog2(MAX_TAPS),
    localparam int N_W     = $clog2(MAX_TAPS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] wr_pos,
    input  logic [N_W-1:0]   tap_cnt,
    input  sample_t          hist_head,
    input  sample_t          hist_up,
    input  sample_t          coef_dn,
    output sample_t          hist_q,
    output sample_t          coef_q,
    output sample_t          coef_tail
);

    localparam logic [IDX_W-1:0]      IDX_P    = IDX_W'(IDX);
    localparam logic [N_W-1:0]        IDX_N    = N_W'(IDX);
    localparam logic [N_W-1:0]        IDX_N1   = N_W'(IDX + 1);
    localparam bit                    IDX_FITS = (IDX < (1 << COEF_IDX_W));
    localparam logic [COEF_IDX_W-1:0] IDX_C    = COEF_IDX_W'(IDX);

    sample_t hist_reg, hist_next;
    sample_t coef_reg, coef_next;
    logic    in_ring;
    logic    is_last;
    logic    coef_hit;

    assign in_ring  = (IDX_N < tap_cnt);
    assign is_last  = (IDX_N1 == tap_cnt);
    assign coef_hit = IDX_FITS && (ctl.coef_index == IDX_C);

    always_comb begin
        hist_next = hist_reg;
        if (ctl.hist_clr) begin
            hist_next = '0;
        end else if (ctl.hist_we && (wr_pos == IDX_P)) begin
            hist_next = ctl.sample;
        end else if (ctl.hist_rot && in_ring) begin
            hist_next = is_last ? hist_head : hist_up;
        end
    end

    always_comb begin
        coef_next = coef_reg;
        if (ctl.coef_we && coef_hit) begin
            coef_next = ctl.coef_value;
        end else if (ctl.coef_rot && in_ring) begin
            coef_next = coef_dn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            coef_reg <= '0;
        end else begin
            hist_reg <= hist_next;
            coef_reg <= coef_next;
        end
    end

    assign hist_q    = hist_reg;
    assign coef_q    = coef_reg;
    assign coef_tail = is_last ? coef_reg : '0;

endmodule

// ===== rtl/core/fcirc_mac.sv =====
// Multiply-accumulate unit fed from the head of the cell chain.
// Registered product, saturating 64-bit accumulator, round and clip to Q1.15.
// Depends on fcirc_pkg.
module fcirc_mac import fcirc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mac_ctl_t ctl,
    input  sample_t  hist_tap,
    input  sample_t  coef_tap,
    output sample_t  y,
    output logic     clip
);

    localparam acc_t ACC_MAX   = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t ACC_MIN   = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam acc_t ROUND_INC = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam sample_t Y_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t Y_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic signed [ACC_BITS:0] sum;
        sum = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
            return sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        return sum[ACC_BITS-1:0];
    endfunction

    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_vld_reg;
    acc_t                        acc_reg, acc_next;
    acc_t                        rounded;
    acc_t                        shifted;
    logic                        in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            prod_reg <= hist_tap * coef_tap;
        end
        acc_reg <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clr) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = sat_add(acc_reg, ACC_BITS'(prod_reg));
        end
    end

    // round half up, floor shift, clip
    assign rounded  = sat_add(acc_reg, ROUND_INC);
    assign shifted  = rounded >>> FRAC_BITS;
    assign in_range = (&shifted[ACC_BITS-1:SAMPLE_BITS-1]) ||
                      !(|shifted[ACC_BITS-1:SAMPLE_BITS-1]);
    assign clip     = !in_range;
    assign y        = in_range ? shifted[SAMPLE_BITS-1:0]
                               : (shifted[ACC_BITS-1] ? Y_MIN : Y_MAX);

endmodule
